>>> rtl/core/pngsu_pkg.sv
// Package for the PNG scanline unfilter: shared constants, filter and
// register codes, and the small modulo helpers for the left-neighbor slot.
// No dependencies.
package pngsu_pkg;

  // Default sizing of the line store and the left-neighbor history
  localparam int MAX_ROW_BYTES_DEF = 4096;
  localparam int MAX_BPP_DEF       = 8;

  // Width the slot helper works on (covers column values up to 131071)
  localparam int COL_FN_W = 17;

  // Configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BPP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  // Filter type codes
  localparam logic [2:0] FLT_NONE  = 3'd0;
  localparam logic [2:0] FLT_SUB   = 3'd1;
  localparam logic [2:0] FLT_UP    = 3'd2;
  localparam logic [2:0] FLT_AVG   = 3'd3;
  localparam logic [2:0] FLT_PAETH = 3'd4;

  // x mod 3 by folding base-4 digits (4 = 1 mod 3)
  function automatic logic [1:0] mod3(input logic [COL_FN_W-1:0] x);
    logic [17:0] xp;
    logic [4:0]  s;
    logic [2:0]  t;
    logic [2:0]  u;
    xp = 18'(x);
    s  = '0;
    for (int i = 0; i < 9; i++) begin
      s = s + 5'(xp[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    u = 3'(t[1:0]) + 3'(t[2]);
    if (u >= 3'd3) begin
      u = u - 3'd3;
    end
    return u[1:0];
  endfunction

  // x mod 5 by folding base-16 digits (16 = 1 mod 5)
  function automatic logic [2:0] mod5(input logic [COL_FN_W-1:0] x);
    logic [19:0] xp;
    logic [6:0]  s;
    logic [4:0]  t;
    logic [4:0]  u;
    xp = 20'(x);
    s  = '0;
    for (int i = 0; i < 5; i++) begin
      s = s + 7'(xp[4*i +: 4]);
    end
    t = 5'(s[3:0]) + 5'(s[6:4]);
    u = 5'(t[3:0]) + 5'(t[4]);
    for (int i = 0; i < 3; i++) begin
      if (u >= 5'd5) begin
        u = u - 5'd5;
      end
    end
    return u[2:0];
  endfunction

  // x mod 7 by folding base-8 digits (8 = 1 mod 7)
  function automatic logic [2:0] mod7(input logic [COL_FN_W-1:0] x);
    logic [17:0] xp;
    logic [5:0]  s;
    logic [3:0]  t;
    logic [3:0]  u;
    xp = 18'(x);
    s  = '0;
    for (int i = 0; i < 6; i++) begin
      s = s + 6'(xp[3*i +: 3]);
    end
    t = 4'(s[2:0]) + 4'(s[5:3]);
    u = 4'(t[2:0]) + 4'(t[3]);
    if (u >= 4'd7) begin
      u = u - 4'd7;
    end
    return u[2:0];
  endfunction

  // column mod bytes-per-pixel, bpp already limited to 1..8
  function automatic logic [2:0] mod_bpp(input logic [COL_FN_W-1:0] x,
                                         input logic [3:0] b);
    logic [1:0] r3;
    logic [2:0] res;
    r3 = mod3(x);
    case (b)
      4'd2:    res = 3'(x[0]);
      4'd3:    res = 3'(r3);
      4'd4:    res = 3'(x[1:0]);
      4'd5:    res = mod5(x);
      // mod 6 from mod 3 and parity
      4'd6:    res = 3'(r3) + (((r3[0] ^ x[0]) == 1'b1) ? 3'd3 : 3'd0);
      4'd7:    res = mod7(x);
      4'd8:    res = x[2:0];
      default: res = 3'd0;
    endcase
    return res;
  endfunction

endpackage

>>> rtl/core/pngsu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pngsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/pngsu_recon.sv
// Byte reconstruction datapath: predictor select (none/sub/up/avg/paeth)
// and the final modulo-256 add. Depends on pngsu_pkg.
module pngsu_recon
  import pngsu_pkg::*;
(
  input  logic [2:0] kind,
  input  logic [7:0] cur,
  input  logic [7:0] left,
  input  logic [7:0] up,
  input  logic [7:0] upleft,
  output logic [7:0] val
);

  logic signed [9:0] d_pa;
  logic signed [9:0] d_pb;
  logic signed [9:0] d_pc;
  logic [9:0]        pa;
  logic [9:0]        pb;
  logic [9:0]        pc;
  logic [7:0]        paeth;
  logic [8:0]        avg_sum;
  logic [7:0]        pred;

  // paeth distances: |b-c|, |a-c|, |a+b-2c|
  always_comb begin
    d_pa = $signed({2'b00, up})   - $signed({2'b00, upleft});
    d_pb = $signed({2'b00, left}) - $signed({2'b00, upleft});
    d_pc = $signed({2'b00, left}) + $signed({2'b00, up})
         - $signed({1'b0, upleft, 1'b0});
    pa = (d_pa < 0) ? 10'(-d_pa) : 10'(d_pa);
    pb = (d_pb < 0) ? 10'(-d_pb) : 10'(d_pb);
    pc = (d_pc < 0) ? 10'(-d_pc) : 10'(d_pc);
    if (pa <= pb && pa <= pc) begin
      paeth = left;
    end else if (pb <= pc) begin
      paeth = up;
    end else begin
      paeth = upleft;
    end
  end

  assign avg_sum = {1'b0, left} + {1'b0, up};

  // predictor select
  always_comb begin
    case (kind)
      FLT_SUB:   pred = left;
      FLT_UP:    pred = up;
      FLT_AVG:   pred = avg_sum[8:1];
      FLT_PAETH: pred = paeth;
      default:   pred = 8'd0;
    endcase
  end

  assign val = cur + pred;

endmodule

>>> rtl/core/png_scanline_unfilter.sv
// PNG scanline unfilter top level. Depends on pngsu_pkg, pngsu_ram, pngsu_recon.
// Pipeline: each byte passes the stage register, then the output register, before
// out_valid rises; the line-store read is issued at the input transfer.
// Throughput: one byte per cycle sustained while out_ready stays high; filter-type
// bytes are accepted but give no result. Synchronous active-low reset clears
// control state; the line store is not cleared and is undefined until a row
// writes it.
module png_scanline_unfilter
  import pngsu_pkg::*;
#(
  parameter int MAX_ROW_BYTES       = MAX_ROW_BYTES_DEF,
  parameter int MAX_BYTES_PER_PIXEL = MAX_BPP_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // input stream
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  // result stream
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_last_in_row,
  output logic                 out_last_in_image,
  output logic                 out_error
);

  localparam int AW = $clog2(MAX_ROW_BYTES);
  localparam int CW = $clog2(MAX_ROW_BYTES + 1);
  localparam int SW = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;

  // configuration registers
  logic [3:0]  bpp_r;
  logic [12:0] width_r;
  logic [15:0] height_r;

  // row/image control state
  logic          awaiting_r, awaiting_nxt;
  logic          first_row_r, first_row_nxt;
  logic          halted_r, halted_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [15:0]   row_cnt_r, row_cnt_nxt;
  logic [2:0]    kind_r, kind_nxt;

  // left/up-left history and per-slot valid bits
  logic [7:0]                     lh_r [MAX_BYTES_PER_PIXEL];
  logic [7:0]                     uh_r [MAX_BYTES_PER_PIXEL];
  logic [MAX_BYTES_PER_PIXEL-1:0] hv_r;

  // stage register
  logic          s1_valid_r, s1_valid_nxt;
  logic          s1_err_r;
  logic [7:0]    s1_cur_r;
  logic [2:0]    s1_kind_r;
  logic [AW-1:0] s1_addr_r;
  logic [SW-1:0] s1_slot_r;
  logic          s1_use_left_r;
  logic          s1_first_row_r;
  logic          s1_row_end_r;
  logic          s1_img_end_r;

  // output register
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_row_r;
  logic       out_img_r;
  logic       out_err_r;

  // derived
  logic [3:0]  bpp_eff;
  logic [12:0] width_eff;
  logic [15:0] height_eff;
  logic [15:0] row_bytes;
  logic        s1_adv;
  logic        in_fire;
  logic        flt_take;
  logic        item_load;
  logic        item_err;
  logic        data_take;
  logic        row_end;
  logic        img_end;
  logic [SW-1:0] slot;
  logic        use_left;
  logic [7:0]  ram_rdata;
  logic [7:0]  up;
  logic [7:0]  left;
  logic [7:0]  upleft;
  logic [7:0]  val;
  logic        hv_sel;

  // effective configuration values
  always_comb begin
    if (bpp_r == 4'd0) begin
      bpp_eff = 4'd1;
    end else if (bpp_r > 4'(MAX_BYTES_PER_PIXEL)) begin
      bpp_eff = 4'(MAX_BYTES_PER_PIXEL);
    end else begin
      bpp_eff = bpp_r;
    end
    width_eff  = (width_r == 13'd0) ? 13'd1 : width_r;
    height_eff = (height_r == 16'd0) ? 16'd1 : height_r;
    row_bytes  = 16'(bpp_eff) * 16'(width_eff);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r    <= 4'd1;
      width_r  <= 13'd1;
      height_r <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BPP:    bpp_r    <= cfg_wdata[3:0];
        CFG_WIDTH:  width_r  <= cfg_wdata[12:0];
        CFG_HEIGHT: height_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // handshakes
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  assign slot     = SW'(mod_bpp(COL_FN_W'(col_r), bpp_eff));
  assign use_left = (col_r >= CW'(bpp_eff));
  assign row_end  = (18'(col_r) + 18'd1) >= 18'(row_bytes);
  assign img_end  = (17'(row_cnt_r) + 17'd1) >= 17'(height_eff);

  // per-item control decisions, made at the input transfer
  always_comb begin
    awaiting_nxt  = awaiting_r;
    first_row_nxt = first_row_r;
    halted_nxt    = halted_r;
    col_nxt       = col_r;
    row_cnt_nxt   = row_cnt_r;
    kind_nxt      = kind_r;
    flt_take      = 1'b0;
    item_load     = 1'b0;
    item_err      = 1'b0;
    data_take     = 1'b0;
    if (in_fire && !halted_r) begin
      if (awaiting_r) begin
        if (in_byte > 8'(FLT_PAETH) || 17'(row_bytes) > 17'(MAX_ROW_BYTES)) begin
          item_load  = 1'b1;
          item_err   = 1'b1;
          halted_nxt = 1'b1;
        end else begin
          flt_take     = 1'b1;
          kind_nxt     = in_byte[2:0];
          awaiting_nxt = 1'b0;
          col_nxt      = '0;
        end
      end else if (col_r >= CW'(MAX_ROW_BYTES)) begin
        item_load  = 1'b1;
        item_err   = 1'b1;
        halted_nxt = 1'b1;
      end else begin
        item_load = 1'b1;
        data_take = 1'b1;
        if (row_end) begin
          awaiting_nxt = 1'b1;
          col_nxt      = '0;
          if (img_end) begin
            row_cnt_nxt   = '0;
            first_row_nxt = 1'b1;
          end else begin
            row_cnt_nxt   = row_cnt_r + 16'd1;
            first_row_nxt = 1'b0;
          end
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r  <= 1'b1;
      first_row_r <= 1'b1;
      halted_r    <= 1'b0;
      col_r       <= '0;
      row_cnt_r   <= '0;
      kind_r      <= FLT_NONE;
    end else begin
      awaiting_r  <= awaiting_nxt;
      first_row_r <= first_row_nxt;
      halted_r    <= halted_nxt;
      col_r       <= col_nxt;
      row_cnt_r   <= row_cnt_nxt;
      kind_r      <= kind_nxt;
    end
  end

  // stage register load
  always_comb begin
    if (item_load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_load) begin
      s1_err_r       <= item_err;
      s1_cur_r       <= in_byte;
      s1_kind_r      <= kind_r;
      s1_addr_r      <= col_r[AW-1:0];
      s1_slot_r      <= slot;
      s1_use_left_r  <= use_left;
      s1_first_row_r <= first_row_r;
      s1_row_end_r   <= row_end;
      s1_img_end_r   <= img_end;
    end
  end

  // previous-row line store: read at transfer, written when the byte completes
  pngsu_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES)
  ) u_line (
    .clk   (clk),
    .we    (s1_adv && !s1_err_r),
    .waddr (s1_addr_r),
    .wdata (val),
    .re    (data_take),
    .raddr (col_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // neighbor selection
  assign hv_sel = hv_r[s1_slot_r];
  assign up     = s1_first_row_r ? 8'd0 : ram_rdata;
  assign left   = (s1_use_left_r && hv_sel) ? lh_r[s1_slot_r] : 8'd0;
  assign upleft = (s1_use_left_r && hv_sel && !s1_first_row_r) ? uh_r[s1_slot_r] : 8'd0;

  pngsu_recon u_recon (
    .kind   (s1_kind_r),
    .cur    (s1_cur_r),
    .left   (left),
    .up     (up),
    .upleft (upleft),
    .val    (val)
  );

  // history valid bits: cleared by a filter byte, set by a completed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= '0;
    end else if (flt_take) begin
      hv_r <= '0;
    end else if (s1_adv && !s1_err_r) begin
      hv_r[s1_slot_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && !s1_err_r) begin
      lh_r[s1_slot_r] <= val;
      uh_r[s1_slot_r] <= up;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_byte_r <= s1_err_r ? 8'd0 : val;
      out_row_r  <= !s1_err_r && s1_row_end_r;
      out_img_r  <= !s1_err_r && s1_row_end_r && s1_img_end_r;
      out_err_r  <= s1_err_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_last_in_row   = out_row_r;
  assign out_last_in_image = out_img_r;
  assign out_error         = out_err_r;

endmodule

>>> tb/tb.sv
// Self-checking testbench for png_scanline_unfilter: filtered PNG scanlines go in,
// reconstructed bytes are predicted per transfer and checked in order.
// Depends on pngsu_pkg and the png_scanline_unfilter RTL.
module tb;
  import pngsu_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int RANDOM_BYTES   = 900;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
    logic       image_end;
    logic       fault;
  } recon_t;

  // DUT connections, all inputs known from time zero
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_BPP;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_byte   = 8'h00;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           out_byte;
  logic                 out_last_in_row;
  logic                 out_last_in_image;
  logic                 out_error;

  png_scanline_unfilter u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_last_in_row   (out_last_in_row),
    .out_last_in_image (out_last_in_image),
    .out_error         (out_error)
  );

  // Stimulus and expectation stores
  logic [7:0] stream_fifo[$];
  recon_t     recon_fifo[$];

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int n_pushed        = 0;
  int n_accepted      = 0;
  int n_checked       = 0;
  int n_rows          = 0;
  int n_images        = 0;
  int n_settings      = 0;
  int n_phases        = 0;
  int fail_count      = 0;
  int quiet_cycles    = 0;
  string halt_kind    = "none";

  // Predictor copy of registers and unfilter state
  logic [3:0]  r_bpp    = 4'd1;
  logic [12:0] r_width  = 13'd1;
  logic [15:0] r_height = 16'd1;
  logic [7:0]  line_mem [MAX_ROW_BYTES_DEF];
  logic [7:0]  left_hist [MAX_BPP_DEF];
  logic [7:0]  upl_hist [MAX_BPP_DEF];
  int unsigned col        = 0;
  int unsigned rows_done  = 0;
  logic [2:0]  cur_filter = FLT_NONE;
  bit          want_filter = 1'b1;
  bit          top_row     = 1'b1;
  bit          stopped     = 1'b0;

  function automatic int unsigned eff_bpp_now();
    if (r_bpp == 4'd0) return 1;
    if (r_bpp > MAX_BPP_DEF) return MAX_BPP_DEF;
    return r_bpp;
  endfunction

  function automatic int unsigned eff_height_now();
    return (r_height == 16'd0) ? 1 : r_height;
  endfunction

  function automatic int unsigned row_bytes_now();
    return eff_bpp_now() * ((r_width == 13'd0) ? 1 : r_width);
  endfunction

  function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    int p;
    int pa;
    int pb;
    int pc;
    p  = int'(a) + int'(b) - int'(c);
    pa = (p > int'(a)) ? p - int'(a) : int'(a) - p;
    pb = (p > int'(b)) ? p - int'(b) : int'(b) - p;
    pc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  // Halt: one error result, then silence
  function automatic void push_fault();
    recon_t r;
    r = '{pixel: 8'h00, row_end: 1'b0, image_end: 1'b0, fault: 1'b1};
    stopped = 1'b1;
    recon_fifo.push_back(r);
  endfunction

  // Advance the predictor by one accepted byte
  function automatic void predict_byte(input logic [7:0] cur);
    int unsigned bpp_e;
    int unsigned slot;
    logic [7:0]  left_v;
    logic [7:0]  up_v;
    logic [7:0]  upl_v;
    logic [7:0]  pred;
    logic [7:0]  pix;
    recon_t      r;
    bpp_e = eff_bpp_now();
    if (stopped) return;
    if (want_filter) begin
      if (cur > 8'(FLT_PAETH) || row_bytes_now() > MAX_ROW_BYTES_DEF) begin
        push_fault();
        return;
      end
      cur_filter  = cur[2:0];
      want_filter = 1'b0;
      col         = 0;
      for (int i = 0; i < MAX_BPP_DEF; i++) begin
        left_hist[i] = 8'h00;
        upl_hist[i]  = 8'h00;
      end
      return;
    end
    if (col >= MAX_ROW_BYTES_DEF) begin
      push_fault();
      return;
    end
    slot   = col % bpp_e;
    left_v = (col >= bpp_e) ? left_hist[slot] : 8'h00;
    upl_v  = (col >= bpp_e && !top_row) ? upl_hist[slot] : 8'h00;
    up_v   = top_row ? 8'h00 : line_mem[col];
    case (cur_filter)
      FLT_SUB:   pred = left_v;
      FLT_UP:    pred = up_v;
      FLT_AVG:   pred = 8'((9'(left_v) + 9'(up_v)) >> 1);
      FLT_PAETH: pred = paeth_pred(left_v, up_v, upl_v);
      default:   pred = 8'h00;
    endcase
    pix            = cur + pred;
    left_hist[slot] = pix;
    upl_hist[slot]  = up_v;
    line_mem[col]   = pix;
    r = '{pixel: pix, row_end: 1'b0, image_end: 1'b0, fault: 1'b0};
    if (col + 1 >= row_bytes_now()) begin
      r.row_end   = 1'b1;
      want_filter = 1'b1;
      col         = 0;
      if (rows_done + 1 >= eff_height_now()) begin
        r.image_end = 1'b1;
        rows_done   = 0;
        top_row     = 1'b1;
      end else begin
        rows_done = (rows_done + 1) & 32'hFFFF;
        top_row   = 1'b0;
      end
    end else begin
      col++;
    end
    recon_fifo.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d want %0d at result %0d", what, got, want, n_checked);
    fail_count++;
  endtask

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Input driver: presents queued bytes, holds each until its transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_byte(in_byte);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (stream_fifo.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_byte  <= stream_fifo.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each transfer against the oldest expectation
  always @(posedge clk) begin
    recon_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (recon_fifo.size() == 0) begin
          report_mismatch("result with nothing pending, byte", out_byte, 0);
        end else begin
          want = recon_fifo.pop_front();
          if (out_byte !== want.pixel)
            report_mismatch("out_byte", out_byte, want.pixel);
          if (out_last_in_row !== want.row_end)
            report_mismatch("out_last_in_row", out_last_in_row, want.row_end);
          if (out_last_in_image !== want.image_end)
            report_mismatch("out_last_in_image", out_last_in_image, want.image_end);
          if (out_error !== want.fault)
            report_mismatch("out_error", out_error, want.fault);
          if (want.row_end) n_rows++;
          if (want.image_end) n_images++;
        end
        n_checked++;
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results pending",
               quiet_cycles, recon_fifo.size());
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    stream_fifo.push_back(b);
    n_pushed++;
  endtask

  // Whole scanlines: filter byte 0..4, then random data with extra 00/FF
  task automatic push_rows(input int nrows);
    int unsigned len;
    int pick;
    len = row_bytes_now();
    for (int r = 0; r < nrows; r++) begin
      push_byte(8'($urandom_range(0, 4)));
      for (int j = 0; j < len; j++) begin
        pick = $urandom_range(0, 15);
        if (pick == 0) push_byte(8'h00);
        else if (pick == 1) push_byte(8'hFF);
        else push_byte(8'($urandom));
      end
    end
  endtask

  // Wait until every byte went in, every result came out, and the pipe settled
  task automatic drain();
    while (n_accepted != n_pushed || recon_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Drain, write all three registers, pick the idling mode for this phase
  task automatic run_phase(input int bpp, input int width, input int height);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [15:0]          dat [3];
    drain();
    idx[0] = CFG_BPP;
    idx[1] = CFG_WIDTH;
    idx[2] = CFG_HEIGHT;
    // unused upper bits carry noise now and then
    dat[0] = 16'(bpp & 'hF) | ($urandom_range(0, 1) ? 16'($urandom) & 16'hFFF0 : 16'h0);
    dat[1] = 16'(width & 'h1FFF) | ($urandom_range(0, 1) ? 16'($urandom) & 16'hE000 : 16'h0);
    dat[2] = 16'(height);
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= dat[i];
      @(posedge clk);
      case (idx[i])
        CFG_BPP:    r_bpp    = dat[i][3:0];
        CFG_WIDTH:  r_width  = dat[i][12:0];
        CFG_HEIGHT: r_height = dat[i];
        default:    ;
      endcase
    end
    cfg_we <= 1'b0;
    n_settings++;
    case (n_phases % 4)
      0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin sender_idle_pct = 45; recv_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  recv_stall_pct = 45; end
      default: begin sender_idle_pct = 24; recv_stall_pct = 24; end
    endcase
    n_phases++;
  endtask

  // Main sequence
  initial begin
    logic [7:0] directed_bytes [25];
    int start_count;
    int bpp_pick;
    directed_bytes = '{
      8'd0, 8'h00, 8'hFF, 8'h80, 8'h7F,   // none
      8'd1, 8'hFF, 8'hFF, 8'h01, 8'h00,   // sub, wraps past 255
      8'd2, 8'h00, 8'hFF, 8'hFF, 8'h01,   // up
      8'd3, 8'hFF, 8'h01, 8'hFE, 8'h03,   // average, floor of odd sums
      8'd4, 8'h00, 8'hFF, 8'h10, 8'hF0    // paeth
    };
    for (int i = 0; i < MAX_BPP_DEF; i++) begin
      left_hist[i] = 8'h00;
      upl_hist[i]  = 8'h00;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 2-byte pixels, 2 pixels per row, one image with every filter
    run_phase(2, 2, 5);
    for (int i = 0; i < 25; i++) push_byte(directed_bytes[i]);

    // Random phases of whole images, mostly small shapes
    start_count = n_pushed;
    while (n_pushed - start_count < RANDOM_BYTES) begin
      bpp_pick = $urandom_range(0, 9);
      if (bpp_pick == 9) bpp_pick = $urandom_range(9, 15);
      run_phase(bpp_pick,
                ($urandom_range(0, 3) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12),
                $urandom_range(0, 6));
      push_rows($urandom_range(1, 3) * eff_height_now());
    end

    // Wide row of 8-byte pixels: second row reads every entry the first wrote
    run_phase(8, 40, 2);
    push_rows(2);

    // Tallest image: a few rows, then a smaller height closes the image early
    run_phase(2, 3, 16'hFFFF);
    push_rows(6);
    run_phase(2, 3, 4);
    push_rows(1 + 4 * $urandom_range(1, 2));

    // Halt: unknown filter byte or an oversized row, then bytes that must vanish
    if ($urandom_range(0, 1) == 0) begin
      halt_kind = "unknown filter byte";
      run_phase($urandom_range(1, 8), $urandom_range(1, 6), $urandom_range(1, 3));
      push_rows(eff_height_now());
      push_byte(8'($urandom_range(5, 255)));
    end else begin
      halt_kind = "row longer than line store";
      if ($urandom_range(0, 1) == 0) run_phase(8, 513, 1);
      else run_phase(15, 8191, 1);
      push_byte(8'($urandom_range(0, 4)));
    end
    for (int i = 0; i < 3; i++) push_byte(8'($urandom));

    drain();
    repeat (20) @(posedge clk);
    $display("summary: %0d bytes in, %0d results checked, %0d register settings",
             n_accepted, n_checked, n_settings);
    $display("summary: %0d rows, %0d images, halted by %s", n_rows, n_images, halt_kind);
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
